// ===== src/rcls_pkg.sv =====
// rcls_pkg: shared types, codes and constants for the rate command limiter
// depends on nothing
package rcls_pkg;
	localparam int ONE_FIX = 65536;
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_ROT = 2'd1;
	localparam logic [1:0] CMD_BODY = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;
	localparam logic CFG_GAIN = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef logic signed [23:0] v24_t;
	typedef logic signed [17:0] m18_t;

	// square-root unit request and reply
	typedef struct packed {
		logic start;
		logic [49:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic done;
		logic [24:0] root;
	} sqrt_rsp_t;

	// divider request and reply (unsigned magnitude / divisor)
	typedef struct packed {
		logic start;
		logic [45:0] dividend;
		logic [24:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [45:0] quotient;
	} div_rsp_t;
endpackage

// ===== src/rcls_sqrt.sv =====
// rcls_sqrt: iterative floor square root, one result bit per cycle
// depends on rcls_pkg
module rcls_sqrt (
	input logic clk,
	input logic arst_n,
	input rcls_pkg::sqrt_req_t req,
	output rcls_pkg::sqrt_rsp_t rsp
);
	import rcls_pkg::*;

	logic [49:0] rad_q;
	logic [25:0] rem_q;
	logic [24:0] res_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [27:0] rem_sh;
	logic [27:0] trial;
	logic fits;

	// restoring method: bring down two bits, try (4*res+1)
	assign rem_sh = {rem_q, rad_q[49:48]};
	assign trial = {1'b0, res_q, 2'b01};
	assign fits = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd24;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q <= req.radicand;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[47:0], 2'b00};
			if (fits) begin
				rem_q <= 26'(rem_sh - trial);
				res_q <= {res_q[23:0], 1'b1};
			end else begin
				rem_q <= rem_sh[25:0];
				res_q <= {res_q[23:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = res_q;
endmodule

// ===== src/rcls_div.sv =====
// rcls_div: iterative unsigned restoring divider, one quotient bit per cycle
// depends on rcls_pkg
module rcls_div (
	input logic clk,
	input logic arst_n,
	input rcls_pkg::div_req_t req,
	output rcls_pkg::div_rsp_t rsp
);
	import rcls_pkg::*;

	logic [45:0] quo_q;
	logic [24:0] rem_q;
	logic [24:0] dvs_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [25:0] sh;

	assign sh = {rem_q, quo_q[45]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd45;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (sh >= {1'b0, dvs_q}) begin
				rem_q <= 25'(sh - {1'b0, dvs_q});
				quo_q <= {quo_q[44:0], 1'b1};
			end else begin
				rem_q <= sh[24:0];
				quo_q <= {quo_q[44:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule

// ===== src/rate_command_limit_smooth_core.sv =====
// rate_command_limit_smooth_core: top level, sequencer and shared multiplier
// depends on rcls_pkg, rcls_sqrt, rcls_div
//
// One transaction at a time. A load or clear transaction is handled in the
// idle state. A step runs a sequencer around one shared 25x25-bit multiplier:
// nine products for the rotation (rotated steps only), three squares, a 25-step
// square root, then, when the magnitude is over the limit, three 46-step
// divisions, and six products for the blend. The result goes to an output
// register; in its last state the sequencer waits only when the previous
// result there has not been taken.
module rate_command_limit_smooth_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [22:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] cmd,
	input logic [1:0] row,
	input rcls_pkg::v24_t val_a,
	input rcls_pkg::v24_t val_b,
	input rcls_pkg::v24_t val_c,
	output logic out_valid,
	input logic out_stall,
	output rcls_pkg::v24_t out_x,
	output rcls_pkg::v24_t out_y,
	output rcls_pkg::v24_t out_z
);
	import rcls_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ROT = 4'd1;
	localparam logic [3:0] ST_SQ = 4'd2;
	localparam logic [3:0] ST_SQRT = 4'd3;
	localparam logic [3:0] ST_DIV = 4'd4;
	localparam logic [3:0] ST_DIVW = 4'd5;
	localparam logic [3:0] ST_BLEND = 4'd6;
	localparam logic [3:0] ST_OUT = 4'd7;
	localparam logic [3:0] ST_SQW = 4'd8;

	logic [3:0] state_q;
	logic [16:0] gain_q;
	logic [22:0] limit_q;
	m18_t rot_q [9];
	v24_t cmd_q [3];
	v24_t t_q [3];
	v24_t v_q [3];
	logic [1:0] i_q;
	logic [1:0] c_q;
	logic signed [49:0] acc_q;
	logic [49:0] sq_q;
	logic [24:0] mag_q;
	logic out_valid_q;
	v24_t out_x_q;
	v24_t out_y_q;
	v24_t out_z_q;

	// shared multiplier operands
	logic signed [24:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [49:0] prod;
	logic [3:0] ridx;
	logic [3:0] lbase;
	logic [16:0] b_eff;

	assign b_eff = gain_q[16] ? 17'd65536 : gain_q;
	assign ridx = 4'({2'b0, i_q} * 4'd3 + {2'b0, c_q});
	assign lbase = 4'({2'b0, row} * 4'd3);
	assign prod = mul_a * mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_ROT: begin
				mul_a = 25'(rot_q[ridx]);
				mul_b = 25'(t_q[c_q]);
			end
			ST_SQ: begin
				mul_a = 25'(v_q[i_q]);
				mul_b = 25'(v_q[i_q]);
			end
			ST_BLEND: begin
				if (c_q == 2'd0) begin
					mul_a = 25'($signed({1'b0, 17'(18'd65536 - {1'b0, b_eff})}));
					mul_b = 25'(cmd_q[i_q]);
				end else begin
					mul_a = 25'($signed({1'b0, b_eff}));
					mul_b = 25'(v_q[i_q]);
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// square root and divider
	sqrt_req_t sq_req;
	sqrt_rsp_t sq_rsp;
	div_req_t dv_req;
	div_rsp_t dv_rsp;
	logic [23:0] vabs;
	logic [45:0] dividend;

	assign sq_req.start = (state_q == ST_SQRT);
	assign sq_req.radicand = sq_q;
	assign vabs = v_q[i_q][23] ? 24'(-v_q[i_q]) : v_q[i_q];
	assign dividend = 46'(vabs) * 46'(limit_q);
	assign dv_req.start = (state_q == ST_DIV);
	assign dv_req.dividend = dividend;
	assign dv_req.divisor = mag_q;

	rcls_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sq_req), .rsp(sq_rsp));
	rcls_div u_div (.clk(clk), .arst_n(arst_n), .req(dv_req), .rsp(dv_rsp));

	logic accept;
	logic out_free;
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// floor shift and saturate of the accumulator
	logic signed [33:0] shr;
	v24_t satv;
	assign shr = 34'(acc_q >>> 16);
	assign satv = (shr > 34'sd8388607) ? 24'sh7FFFFF :
		(shr < -34'sd8388608) ? 24'sh800000 : shr[23:0];

	m18_t ld [3];
	always_comb begin
		ld[0] = (val_a > 24'sd131071) ? 18'sh1FFFF :
			(val_a < -24'sd131072) ? 18'sh20000 : val_a[17:0];
		ld[1] = (val_b > 24'sd131071) ? 18'sh1FFFF :
			(val_b < -24'sd131072) ? 18'sh20000 : val_b[17:0];
		ld[2] = (val_c > 24'sd131071) ? 18'sh1FFFF :
			(val_c < -24'sd131072) ? 18'sh20000 : val_c[17:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gain_q <= '0;
			limit_q <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 9; k++)
				rot_q[k] <= (k % 4 == 0) ? 18'sd65536 : 18'sd0;
			for (int k = 0; k < 3; k++)
				cmd_q[k] <= '0;
			i_q <= '0;
			c_q <= '0;
			mag_q <= '0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_z_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_GAIN)
					gain_q <= cfg_data[16:0];
				else
					limit_q <= cfg_data;
			end
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						i_q <= '0;
						c_q <= '0;
						unique case (cmd)
							CMD_LOAD: begin
								if (row != 2'd3) begin
									rot_q[lbase] <= ld[0];
									rot_q[lbase + 4'd1] <= ld[1];
									rot_q[lbase + 4'd2] <= ld[2];
								end
							end
							CMD_CLEAR: begin
								for (int k = 0; k < 3; k++)
									cmd_q[k] <= '0;
							end
							CMD_ROT: state_q <= ST_ROT;
							CMD_BODY: state_q <= ST_SQ;
							default: ;
						endcase
					end
				end
				ST_ROT: begin
					if (c_q == 2'd2) begin
						c_q <= '0;
						if (i_q == 2'd2) begin
							i_q <= '0;
							state_q <= ST_SQW;
						end else begin
							i_q <= i_q + 2'd1;
						end
					end else begin
						c_q <= c_q + 2'd1;
					end
				end
				ST_SQW: state_q <= ST_SQ;
				ST_SQ: begin
					if (i_q == 2'd2) begin
						i_q <= '0;
						state_q <= ST_SQRT;
					end else begin
						i_q <= i_q + 2'd1;
					end
				end
				ST_SQRT: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (sq_rsp.done) begin
						mag_q <= sq_rsp.root;
						if ({1'b0, sq_rsp.root} > {3'b0, limit_q}) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_BLEND;
						end
						i_q <= '0;
						c_q <= '0;
					end else if (dv_rsp.done) begin
						if (i_q == 2'd2) begin
							i_q <= '0;
							state_q <= ST_BLEND;
						end else begin
							i_q <= i_q + 2'd1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: state_q <= ST_DIVW;
				ST_BLEND: begin
					if (c_q == 2'd0) begin
						c_q <= 2'd1;
						if (i_q != 2'd0)
							cmd_q[i_q - 2'd1] <= satv;
					end else begin
						c_q <= '0;
						if (i_q == 2'd2) begin
							i_q <= '0;
							state_q <= ST_OUT;
						end else begin
							i_q <= i_q + 2'd1;
						end
					end
				end
				ST_OUT: begin
					// hold here while the previous result is still waiting
					if (out_free) begin
						cmd_q[2] <= satv;
						out_x_q <= cmd_q[0];
						out_y_q <= cmd_q[1];
						out_z_q <= satv;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath accumulation; writes of v happen one step behind
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q[0] <= val_a;
			t_q[1] <= val_b;
			t_q[2] <= val_c;
			v_q[0] <= val_a;
			v_q[1] <= val_b;
			v_q[2] <= val_c;
			acc_q <= '0;
			sq_q <= '0;
		end
		unique case (state_q)
			ST_ROT: begin
				if (c_q == 2'd0)
					acc_q <= prod;
				else
					acc_q <= acc_q + prod;
				if (c_q == 2'd0 && i_q != 2'd0)
					v_q[i_q - 2'd1] <= satv;
			end
			ST_SQW: v_q[2] <= satv;
			ST_SQ: begin
				if (i_q == 2'd0)
					sq_q <= 50'(prod);
				else
					sq_q <= sq_q + 50'(prod);
			end
			ST_DIVW: begin
				if (dv_rsp.done)
					v_q[i_q] <= v_q[i_q][23] ? 24'(-dv_rsp.quotient[23:0])
						: dv_rsp.quotient[23:0];
			end
			ST_BLEND: begin
				if (c_q == 2'd0)
					acc_q <= prod;
				else
					acc_q <= acc_q + prod;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_z = out_z_q;
endmodule

// ===== sim/rate_command_limit_smooth_core_tb.sv =====
// rate_command_limit_smooth_core_tb: self-checking testbench for the rate command limiter
// depends on rcls_pkg and rate_command_limit_smooth_core; a directed table, then random
// transactions under several register settings, checked against a built-in predictor or typed values
`timescale 1ns / 1ps

module rate_command_limit_smooth_core_tb;
	import rcls_pkg::*;

	typedef struct {
		logic [1:0] cmd;
		logic [1:0] row;
		v24_t a, b, c;
		bit typed;
		v24_t ex, ey, ez;
	} stim_t;

	typedef struct {
		v24_t x, y, z;
	} rate_vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_GAIN;
	logic [22:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = CMD_BODY;
	logic [1:0] row = '0;
	v24_t val_a = '0, val_b = '0, val_c = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	v24_t out_x, out_y, out_z;

	rate_command_limit_smooth_core uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	longint rot_m [9];
	longint cmd_vec [3];
	longint gain_r, limit_r;

	rate_vec_t cmd_queue [$];
	stim_t dir_rows [$];
	int fail_cnt = 0;
	int burst_left = 0;

	function automatic longint sat_v(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned res = 0;
		longint unsigned bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	task automatic predict_rate(input stim_t s, output bit emits, output rate_vec_t r);
		longint t [3];
		longint v [3];
		longint acc, b;
		longint unsigned sq, mag;
		emits = 0;
		r = '{default: '0};
		t[0] = s.a; t[1] = s.b; t[2] = s.c;
		if (s.cmd == CMD_LOAD) begin
			if (s.row < 3)
				for (int k = 0; k < 3; k++)
					rot_m[s.row * 3 + k] = sat_v(t[k], -131072, 131071);
			return;
		end
		if (s.cmd == CMD_CLEAR) begin
			for (int k = 0; k < 3; k++)
				cmd_vec[k] = 0;
			return;
		end
		if (s.cmd == CMD_ROT) begin
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += rot_m[i * 3 + k] * t[k];
				v[i] = sat_v(acc >>> 16, -8388608, 8388607);
			end
		end else begin
			for (int i = 0; i < 3; i++)
				v[i] = t[i];
		end
		sq = 0;
		for (int i = 0; i < 3; i++)
			sq += longint'(v[i] * v[i]);
		mag = floor_sqrt(sq);
		if (mag > limit_r && mag != 0)
			for (int i = 0; i < 3; i++)
				v[i] = (v[i] * limit_r) / longint'(mag);
		b = (gain_r > ONE_FIX) ? ONE_FIX : gain_r;
		for (int i = 0; i < 3; i++) begin
			acc = (ONE_FIX - b) * cmd_vec[i] + b * v[i];
			cmd_vec[i] = sat_v(acc >>> 16, -8388608, 8388607);
		end
		emits = 1;
		r.x = cmd_vec[0]; r.y = cmd_vec[1]; r.z = cmd_vec[2];
	endtask

	function automatic stim_t mk(logic [1:0] c, logic [1:0] r, v24_t a, v24_t b, v24_t d,
			bit typed = 0, v24_t ex = 0, v24_t ey = 0, v24_t ez = 0);
		stim_t s;
		s.cmd = c; s.row = r; s.a = a; s.b = b; s.c = d;
		s.typed = typed; s.ex = ex; s.ey = ey; s.ez = ez;
		return s;
	endfunction

	function automatic v24_t rand_rate();
		v24_t v = v24_t'($urandom);
		case ($urandom_range(0, 5))
			0: v = 24'sh7FFFFF;
			1: v = 24'sh800000;
			2: v = v >>> $urandom_range(4, 20);
			default: ;
		endcase
		return v;
	endfunction

	// mostly plausible matrix entries, some past the 18-bit range
	function automatic v24_t rand_entry();
		v24_t v = v24_t'($urandom);
		if ($urandom_range(0, 3) != 0)
			v = v >>> $urandom_range(6, 9);
		return v;
	endfunction

	function automatic stim_t rand_item();
		int p = $urandom_range(0, 99);
		if (p < 15)
			return mk(CMD_LOAD, 2'($urandom_range(0, 3)), rand_entry(), rand_entry(),
				rand_entry());
		else if (p < 50)
			return mk(CMD_ROT, 2'($urandom), rand_rate(), rand_rate(), rand_rate());
		else if (p < 90)
			return mk(CMD_BODY, 2'($urandom), rand_rate(), rand_rate(), rand_rate());
		return mk(CMD_CLEAR, 2'($urandom), rand_rate(), rand_rate(), rand_rate());
	endfunction

	task automatic send_item(input stim_t s);
		bit emits;
		rate_vec_t r;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 15);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		cmd <= s.cmd; row <= s.row;
		val_a <= s.a; val_b <= s.b; val_c <= s.c;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		burst_left--;
		predict_rate(s, emits, r);
		if (emits) begin
			if (s.typed) begin
				r.x = s.ex; r.y = s.ey; r.z = s.ez;
			end
			cmd_queue.push_back(r);
		end
	endtask

	// sender pauses until every command is back and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (cmd_queue.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [22:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_GAIN)
			gain_r = data & 23'h1FFFF;
		else
			limit_r = data;
	endtask

	// receiver stall pattern: free, sparse, half, or solid stretches
	int stall_mode = 0, stall_left = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(1, 60);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 1);
			default: out_stall <= (stall_left > 30);
		endcase
	end

	always @(posedge clk) begin
		rate_vec_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (cmd_queue.size() == 0) begin
				$display("%0t: unexpected transaction x=%0d y=%0d z=%0d", $realtime,
					out_x, out_y, out_z);
				fail_cnt++;
			end else begin
				e = cmd_queue.pop_front();
				if (out_x !== e.x || out_y !== e.y || out_z !== e.z) begin
					$display("%0t: mismatch expected (%0d %0d %0d) actual (%0d %0d %0d)",
						$realtime, e.x, e.y, e.z, out_x, out_y, out_z);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic [22:0] g, l;
		for (int i = 0; i < 9; i++)
			rot_m[i] = (i % 4 == 0) ? ONE_FIX : 0;
		for (int i = 0; i < 3; i++)
			cmd_vec[i] = 0;
		gain_r = 0;
		limit_r = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero gain holds the command at zero
		dir_rows.push_back(mk(CMD_BODY, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1));
		dir_rows.push_back(mk(CMD_BODY, 3, 24'sh800000, 24'sh800000, 24'sh800000, 1));
		dir_rows.push_back(mk(CMD_ROT, 0, 24'sh123456, -24'sh0F0F0F, 24'sh7FFFFF, 1));
		dir_rows.push_back(mk(CMD_CLEAR, 0, 0, 0, 0));
		foreach (dir_rows[i])
			send_item(dir_rows[i]);
		drain();
		dir_rows.delete();

		// gain above one acts as one, limit at its top
		write_reg(CFG_GAIN, 23'h1FFFF);
		write_reg(CFG_LIMIT, 23'h7FFFFF);
		dir_rows.push_back(mk(CMD_BODY, 0, 100, 200, -300, 1, 100, 200, -300));
		dir_rows.push_back(mk(CMD_BODY, 0, 24'sh800000, 0, 0, 1, -24'sh7FFFFF, 0, 0));
		dir_rows.push_back(mk(CMD_BODY, 0, 24'sh7FFFFF, 0, 0, 1, 24'sh7FFFFF, 0, 0));
		dir_rows.push_back(mk(CMD_BODY, 0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF));
		dir_rows.push_back(mk(CMD_ROT, 1, 5000, -7000, 9000, 1, 5000, -7000, 9000));
		dir_rows.push_back(mk(CMD_CLEAR, 0, 1, 2, 3));
		dir_rows.push_back(mk(CMD_LOAD, 0, 200000, -200000, 5));
		dir_rows.push_back(mk(CMD_LOAD, 3, 1, 1, 1));
		dir_rows.push_back(mk(CMD_LOAD, 1, 0, -65536, 32768));
		dir_rows.push_back(mk(CMD_LOAD, 2, 24'sh7FFFFF, 24'sh800000, 65536));
		dir_rows.push_back(mk(CMD_ROT, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
		dir_rows.push_back(mk(CMD_ROT, 2, 24'sh800000, 1234, -1));
		dir_rows.push_back(mk(CMD_ROT, 0, 1000, 2000, 3000));
		dir_rows.push_back(mk(CMD_CLEAR, 3, 0, 0, 0));
		dir_rows.push_back(mk(CMD_BODY, 1, -1, -1, -1, 1, -1, -1, -1));
		foreach (dir_rows[i])
			send_item(dir_rows[i]);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 5)
				0: begin g = 23'd65536; l = 23'h7FFFFF; end
				1: begin g = 23'd0; l = 23'd0; end
				2: begin g = 23'($urandom_range(0, 65536)); l = 23'($urandom_range(0, 2000000)); end
				3: begin g = 23'h1FFFF; l = 23'($urandom); end
				default: begin g = 23'($urandom); l = 23'($urandom_range(0, 200000)); end
			endcase
			write_reg(CFG_GAIN, g);
			write_reg(CFG_LIMIT, l);
			for (int n = 0; n < 175; n++)
				send_item(rand_item());
			drain();
		end

		if (fail_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
